/* sv/cpm_pkg.sv */
// shared widths, codes and types of the coincidence pair merger
package cpm_pkg;

    localparam int TIME_BITS  = 48;
    localparam int PHASE_BITS = 16;
    localparam int TAG_BITS   = 16;
    localparam int POS_BITS   = 8;

    localparam int KIND_W   = 3;
    localparam int NEED_W   = 2;
    localparam int CDIFF_W  = 22;
    localparam int FDIFF_W  = 20;
    localparam int CNT_W    = 32;
    localparam int WIN_W    = 20;
    localparam int DELAY_W  = 21;
    localparam int PERIOD_W = 20;
    localparam int PROD_W   = PHASE_BITS + PERIOD_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [KIND_W-1:0] KIND_WAIT     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ACCEPT   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REJECT   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LDROP    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RDROP    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_OVERRUN  = 3'd5;

    localparam logic [NEED_W-1:0] NEED_LEFT   = 2'd0;
    localparam logic [NEED_W-1:0] NEED_RIGHT  = 2'd1;
    localparam logic [NEED_W-1:0] NEED_EITHER = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd2;

    localparam logic [WIN_W-1:0]           WINDOW_RST = 20'd10;
    localparam logic signed [DELAY_W-1:0]  DELAY_RST  = 21'sd0;
    localparam logic [PERIOD_W-1:0]        PERIOD_RST = 20'd1000;

    localparam logic ACTION_LEFT = 1'b0;

    typedef struct packed {
        logic [TIME_BITS-1:0]  coarse_time;
        logic [PHASE_BITS-1:0] fine_phase;
        logic                  fine_valid;
        logic [POS_BITS-1:0]   position;
        logic [TAG_BITS-1:0]   event_tag;
    } t_event;

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [NEED_W-1:0]     need_side;
        logic [TIME_BITS-1:0]  event_time;
        logic [CDIFF_W-1:0]    coarse_diff;
        logic                  fine_neg;
        logic [PHASE_BITS-1:0] fine_mag;
        logic [TAG_BITS-1:0]   left_tag;
        logic [TAG_BITS-1:0]   right_tag;
        logic [CNT_W-1:0]      accepted_count;
        logic [CNT_W-1:0]      dropped_count;
    } t_rec;

endpackage

/* sv/cpm_front.sv */
// front end: takes single items, holds one per side and classifies each step
module cpm_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_push,
    input  logic                                  i_full,
    input  logic                                  i_action,
    input  logic [cpm_pkg::TIME_BITS-1:0]         i_coarse_time,
    input  logic [cpm_pkg::PHASE_BITS-1:0]        i_fine_phase,
    input  logic                                  i_fine_valid,
    input  logic [cpm_pkg::POS_BITS-1:0]          i_position,
    input  logic [cpm_pkg::TAG_BITS-1:0]          i_event_tag,
    input  logic [cpm_pkg::WIN_W-1:0]             i_window,
    input  logic signed [cpm_pkg::DELAY_W-1:0]    i_delay,
    output logic                                  o_accept,
    output cpm_pkg::t_rec                         o_rec
);

    localparam int DW = cpm_pkg::TIME_BITS + 1;
    localparam int SW = cpm_pkg::CDIFF_W + 1;
    localparam int VW = cpm_pkg::CDIFF_W + 2;
    localparam int PW = cpm_pkg::PHASE_BITS + 2;
    localparam logic signed [PW-1:0] PH_HALF = PW'(2 ** (cpm_pkg::PHASE_BITS - 1));
    localparam logic signed [PW-1:0] PH_FULL = PW'(2 ** cpm_pkg::PHASE_BITS);

    logic                        r_left_held;
    logic                        r_right_held;
    cpm_pkg::t_event             r_left_ev;
    cpm_pkg::t_event             r_right_ev;
    logic [cpm_pkg::CNT_W-1:0]   r_acc_total;
    logic [cpm_pkg::CNT_W-1:0]   r_drop_total;

    logic                        n_left_held;
    logic                        n_right_held;
    logic [cpm_pkg::CNT_W-1:0]   n_acc_total;
    logic [cpm_pkg::CNT_W-1:0]   n_drop_total;

    cpm_pkg::t_event             new_ev;
    cpm_pkg::t_event             ev_l;
    cpm_pkg::t_event             ev_r;
    logic                        side_held;
    logic                        other_held;
    logic [DW-1:0]               tdiff;
    logic [DW-1-cpm_pkg::CDIFF_W:0] tdiff_hi;
    logic                        in_range;
    logic signed [SW-1:0]        sdiff;
    logic signed [VW-1:0]        vsum;
    logic [VW-1:0]               vabs;
    logic                        in_win;
    logic signed [PW-1:0]        pdiff;
    logic signed [PW-1:0]        pwrap;
    logic [PW-1:0]               pabs;
    cpm_pkg::t_rec               rec;

    assign o_accept = i_push && !i_full;
    assign o_rec    = rec;

    always_comb begin
        new_ev.coarse_time = i_coarse_time;
        new_ev.fine_phase  = i_fine_phase;
        new_ev.fine_valid  = i_fine_valid;
        new_ev.position    = i_position;
        new_ev.event_tag   = i_event_tag;

        if (i_action == cpm_pkg::ACTION_LEFT) begin
            ev_l       = new_ev;
            ev_r       = r_right_ev;
            side_held  = r_left_held;
            other_held = r_right_held;
        end else begin
            ev_l       = r_left_ev;
            ev_r       = new_ev;
            side_held  = r_right_held;
            other_held = r_left_held;
        end

        // coarse difference and window test
        tdiff    = {1'b0, ev_l.coarse_time} - {1'b0, ev_r.coarse_time};
        tdiff_hi = tdiff[DW-1:cpm_pkg::CDIFF_W];
        in_range = (tdiff_hi == '0) ||
                   ((&tdiff_hi) && (tdiff[cpm_pkg::CDIFF_W-1:0] != '0));
        sdiff    = signed'(tdiff[SW-1:0]);
        vsum     = signed'({sdiff[SW-1], sdiff}) +
                   signed'({{(VW-cpm_pkg::DELAY_W){i_delay[cpm_pkg::DELAY_W-1]}}, i_delay});
        vabs     = vsum[VW-1] ? unsigned'(-vsum) : unsigned'(vsum);
        in_win   = in_range && (vabs < {{(VW-cpm_pkg::WIN_W){1'b0}}, i_window});

        // wrapped fine phase difference
        pdiff = signed'({2'b00, ev_l.fine_phase}) - signed'({2'b00, ev_r.fine_phase});
        if (pdiff < -PH_HALF) begin
            pwrap = pdiff + PH_FULL;
        end else if (pdiff > PH_HALF) begin
            pwrap = pdiff - PH_FULL;
        end else begin
            pwrap = pdiff;
        end
        pabs = pwrap[PW-1] ? unsigned'(-pwrap) : unsigned'(pwrap);

        rec          = '0;
        rec.kind     = cpm_pkg::KIND_WAIT;
        n_left_held  = r_left_held;
        n_right_held = r_right_held;
        n_acc_total  = r_acc_total;
        n_drop_total = r_drop_total;

        if (side_held) begin
            rec.kind = cpm_pkg::KIND_OVERRUN;
        end else begin
            if (i_action == cpm_pkg::ACTION_LEFT) begin
                n_left_held = 1'b1;
            end else begin
                n_right_held = 1'b1;
            end
            if (other_held) begin
                if (in_win) begin
                    rec.event_time  = ev_l.coarse_time;
                    rec.coarse_diff = sdiff[cpm_pkg::CDIFF_W-1:0];
                    rec.fine_neg    = pwrap[PW-1];
                    rec.fine_mag    = pabs[cpm_pkg::PHASE_BITS-1:0];
                    rec.left_tag    = ev_l.event_tag;
                    rec.right_tag   = ev_r.event_tag;
                    if (ev_l.fine_valid && ev_r.fine_valid &&
                        (ev_l.position == ev_r.position)) begin
                        rec.kind    = cpm_pkg::KIND_ACCEPT;
                        n_acc_total = r_acc_total + 1'b1;
                    end else begin
                        rec.kind = cpm_pkg::KIND_REJECT;
                    end
                    n_left_held  = 1'b0;
                    n_right_held = 1'b0;
                end else begin
                    n_drop_total = r_drop_total + 1'b1;
                    if (tdiff[DW-1]) begin
                        rec.kind     = cpm_pkg::KIND_LDROP;
                        rec.left_tag = ev_l.event_tag;
                        n_left_held  = 1'b0;
                    end else begin
                        rec.kind      = cpm_pkg::KIND_RDROP;
                        rec.right_tag = ev_r.event_tag;
                        n_right_held  = 1'b0;
                    end
                end
            end
        end

        if (n_left_held && !n_right_held) begin
            rec.need_side = cpm_pkg::NEED_RIGHT;
        end else if (n_right_held && !n_left_held) begin
            rec.need_side = cpm_pkg::NEED_LEFT;
        end else begin
            rec.need_side = cpm_pkg::NEED_EITHER;
        end
        rec.accepted_count = n_acc_total;
        rec.dropped_count  = n_drop_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_held  <= 1'b0;
            r_right_held <= 1'b0;
            r_acc_total  <= '0;
            r_drop_total <= '0;
        end else if (o_accept) begin
            r_left_held  <= n_left_held;
            r_right_held <= n_right_held;
            r_acc_total  <= n_acc_total;
            r_drop_total <= n_drop_total;
        end
    end

    // event store, no reset
    always_ff @(posedge i_clk) begin
        if (o_accept && !side_held) begin
            if (i_action == cpm_pkg::ACTION_LEFT) begin
                r_left_ev <= new_ev;
            end else begin
                r_right_ev <= new_ev;
            end
        end
    end

    a_overrun_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_accept && rec.kind == cpm_pkg::KIND_OVERRUN)
        |=> ($stable(r_left_held) && $stable(r_right_held) && $stable(r_acc_total)))
        else $error("overrun item changed held state");

    a_pair_clears_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_accept && (rec.kind == cpm_pkg::KIND_ACCEPT || rec.kind == cpm_pkg::KIND_REJECT))
        |=> (!r_left_held && !r_right_held))
        else $error("pair left an event held");

    a_drop_counts_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_accept && (rec.kind == cpm_pkg::KIND_LDROP || rec.kind == cpm_pkg::KIND_RDROP))
        |=> (r_drop_total == $past(r_drop_total) + 1'b1) && (r_left_held != r_right_held))
        else $error("drop bookkeeping wrong");

endmodule

/* sv/cpm_queue.sv */
// short queue of classified items between front and back
module cpm_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cpm_pkg::t_rec i_rec,
    input  logic          i_take,
    output logic          o_valid,
    output cpm_pkg::t_rec o_rec,
    output logic          o_full
);

    cpm_pkg::t_rec                 r_mem [cpm_pkg::QUEUE_DEPTH];
    logic [cpm_pkg::QPTR_W-1:0]    r_wptr;
    logic [cpm_pkg::QPTR_W-1:0]    r_rptr;
    logic [cpm_pkg::QCNT_W-1:0]    r_count;
    logic                          take_ok;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == cpm_pkg::QCNT_W'(cpm_pkg::QUEUE_DEPTH));
    assign o_rec   = r_mem[r_rptr];
    assign take_ok = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (take_ok) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !take_ok) begin
                r_count <= r_count + 1'b1;
            end else if (take_ok && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_rec;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push || take_ok)
        else $error("item written into a full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= cpm_pkg::QCNT_W'(cpm_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != cpm_pkg::QCNT_W'(cpm_pkg::QUEUE_DEPTH)) |->
        (cpm_pkg::QPTR_W'(r_wptr - r_rptr) == cpm_pkg::QPTR_W'(r_count)))
        else $error("queue pointers disagree with count");

endmodule

/* sv/cpm_back.sv */
// back end: fine difference scaling, rounding, saturation and result register
module cpm_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_q_valid,
    input  cpm_pkg::t_rec                        i_q_rec,
    input  logic [cpm_pkg::PERIOD_W-1:0]         i_period,
    input  logic                                 i_pop,
    output logic                                 o_q_take,
    output logic                                 o_empty,
    output logic [cpm_pkg::KIND_W-1:0]           o_kind,
    output logic [cpm_pkg::NEED_W-1:0]           o_need_side,
    output logic [cpm_pkg::TIME_BITS-1:0]        o_event_time,
    output logic signed [cpm_pkg::CDIFF_W-1:0]   o_coarse_diff,
    output logic signed [cpm_pkg::FDIFF_W-1:0]   o_fine_diff_ps,
    output logic [cpm_pkg::TAG_BITS-1:0]         o_left_tag,
    output logic [cpm_pkg::TAG_BITS-1:0]         o_right_tag,
    output logic [cpm_pkg::CNT_W-1:0]            o_accepted_count,
    output logic [cpm_pkg::CNT_W-1:0]            o_dropped_count
);

    localparam int RW = cpm_pkg::PROD_W + 1 - cpm_pkg::PHASE_BITS;
    localparam logic [cpm_pkg::PROD_W:0] RND_HALF =
        (cpm_pkg::PROD_W + 1)'(2 ** (cpm_pkg::PHASE_BITS - 1));
    localparam logic [RW-1:0] POS_MAX = RW'(2 ** (cpm_pkg::FDIFF_W - 1) - 1);
    localparam logic [RW-1:0] NEG_MAG = RW'(2 ** (cpm_pkg::FDIFF_W - 1));

    logic                              r_m_valid;
    cpm_pkg::t_rec                     r_m_rec;
    logic [cpm_pkg::PROD_W-1:0]        r_m_prod;
    logic                              r_o_valid;
    logic [cpm_pkg::KIND_W-1:0]        r_o_kind;
    logic [cpm_pkg::NEED_W-1:0]        r_o_need;
    logic [cpm_pkg::TIME_BITS-1:0]     r_o_time;
    logic [cpm_pkg::CDIFF_W-1:0]       r_o_cdiff;
    logic [cpm_pkg::FDIFF_W-1:0]       r_o_fdiff;
    logic [cpm_pkg::TAG_BITS-1:0]      r_o_ltag;
    logic [cpm_pkg::TAG_BITS-1:0]      r_o_rtag;
    logic [cpm_pkg::CNT_W-1:0]         r_o_acc;
    logic [cpm_pkg::CNT_W-1:0]         r_o_drop;

    logic [cpm_pkg::FDIFF_W-1:0]       n_o_fdiff;
    logic                              out_load;
    logic [cpm_pkg::PROD_W:0]          rsum;
    logic [RW-1:0]                     rq;
    logic [RW-1:0]                     rq_neg;

    assign out_load = r_m_valid && (!r_o_valid || i_pop);
    assign o_q_take = i_q_valid && (!r_m_valid || out_load);
    assign o_empty  = !r_o_valid;

    always_comb begin
        rsum   = {1'b0, r_m_prod} + RND_HALF;
        rq     = rsum[cpm_pkg::PROD_W:cpm_pkg::PHASE_BITS];
        rq_neg = ~rq + 1'b1;
        if (!r_m_rec.fine_neg) begin
            n_o_fdiff = (rq > POS_MAX) ? POS_MAX[cpm_pkg::FDIFF_W-1:0]
                                       : rq[cpm_pkg::FDIFF_W-1:0];
        end else begin
            n_o_fdiff = (rq > NEG_MAG) ? NEG_MAG[cpm_pkg::FDIFF_W-1:0]
                                       : rq_neg[cpm_pkg::FDIFF_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_q_take) begin
                r_m_valid <= 1'b1;
            end else if (out_load) begin
                r_m_valid <= 1'b0;
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_pop) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // multiply stage
    always_ff @(posedge i_clk) begin
        if (o_q_take) begin
            r_m_rec  <= i_q_rec;
            r_m_prod <= {{cpm_pkg::PERIOD_W{1'b0}}, i_q_rec.fine_mag} *
                        {{cpm_pkg::PHASE_BITS{1'b0}}, i_period};
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_kind  <= r_m_rec.kind;
            r_o_need  <= r_m_rec.need_side;
            r_o_time  <= r_m_rec.event_time;
            r_o_cdiff <= r_m_rec.coarse_diff;
            r_o_fdiff <= n_o_fdiff;
            r_o_ltag  <= r_m_rec.left_tag;
            r_o_rtag  <= r_m_rec.right_tag;
            r_o_acc   <= r_m_rec.accepted_count;
            r_o_drop  <= r_m_rec.dropped_count;
        end
    end

    assign o_kind           = r_o_kind;
    assign o_need_side      = r_o_need;
    assign o_event_time     = r_o_time;
    assign o_coarse_diff    = signed'(r_o_cdiff);
    assign o_fine_diff_ps   = signed'(r_o_fdiff);
    assign o_left_tag       = r_o_ltag;
    assign o_right_tag      = r_o_rtag;
    assign o_accepted_count = r_o_acc;
    assign o_dropped_count  = r_o_drop;

    a_no_loss_in_mult: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !out_load) |-> !o_q_take)
        else $error("multiply stage overwritten while full");

    a_zero_mag_zero_ps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_rec.fine_mag == '0) |-> (n_o_fdiff == '0))
        else $error("zero phase difference gave nonzero ps");

    a_result_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !i_pop) |=> (r_o_valid && $stable(r_o_acc) && $stable(r_o_kind)))
        else $error("waiting result lost while stalled");

endmodule

/* sv/coincidence_pair_merger_unit.sv */
// top level of the coincidence pair merger with its configuration registers
// Pairs time-sorted single items from a left and a right detector stream.
// Input channel: present an item and raise push; it is taken at a rising
// edge where push is high and full is low. action selects the side.
// Result channel: while empty is low the oldest result is on the o_ ports;
// it is taken at a rising edge where pop is high. Every input item gives
// exactly one result, in input order.
// Configuration: i_cfg_we with i_cfg_idx 0 window, 1 delay, 2 period in ps;
// to be written by the user only while no item is in flight; the block
// does not enforce this. A taken item is classified into the queue,
// then passes the multiply stage and the result register.
// Throughput: one item per cycle while full is low; the held-event compare
// and window test complete in the cycle the item is taken, the fine
// scaling multiply has a stage of its own behind a four-item queue.
// When the receiver stalls, the result register holds, the multiply stage
// and queue fill, and full rises once four items wait in the queue.
// Reset clears the held flags, counters and queue; the configuration
// returns to window 10, delay 0 and period 1000 ps.
module coincidence_pair_merger_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [cpm_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [cpm_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                 push,
    output logic                                 full,
    input  logic                                 i_action,
    input  logic [cpm_pkg::TIME_BITS-1:0]        i_coarse_time,
    input  logic [cpm_pkg::PHASE_BITS-1:0]       i_fine_phase,
    input  logic                                 i_fine_valid,
    input  logic [cpm_pkg::POS_BITS-1:0]         i_position,
    input  logic [cpm_pkg::TAG_BITS-1:0]         i_event_tag,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [cpm_pkg::KIND_W-1:0]           o_kind,
    output logic [cpm_pkg::NEED_W-1:0]           o_need_side,
    output logic [cpm_pkg::TIME_BITS-1:0]        o_event_time,
    output logic signed [cpm_pkg::CDIFF_W-1:0]   o_coarse_diff,
    output logic signed [cpm_pkg::FDIFF_W-1:0]   o_fine_diff_ps,
    output logic [cpm_pkg::TAG_BITS-1:0]         o_left_tag,
    output logic [cpm_pkg::TAG_BITS-1:0]         o_right_tag,
    output logic [cpm_pkg::CNT_W-1:0]            o_accepted_count,
    output logic [cpm_pkg::CNT_W-1:0]            o_dropped_count
);

    logic [cpm_pkg::WIN_W-1:0]           r_window;
    logic signed [cpm_pkg::DELAY_W-1:0]  r_delay;
    logic [cpm_pkg::PERIOD_W-1:0]        r_period;

    logic          front_accept;
    cpm_pkg::t_rec front_rec;
    logic          q_valid;
    cpm_pkg::t_rec q_rec;
    logic          q_full;
    logic          q_take;

    assign full = q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= cpm_pkg::WINDOW_RST;
            r_delay  <= cpm_pkg::DELAY_RST;
            r_period <= cpm_pkg::PERIOD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cpm_pkg::CFG_WINDOW: begin
                    r_window <= i_cfg_data[cpm_pkg::WIN_W-1:0];
                end
                cpm_pkg::CFG_DELAY: begin
                    r_delay <= signed'(i_cfg_data[cpm_pkg::DELAY_W-1:0]);
                end
                cpm_pkg::CFG_PERIOD: begin
                    r_period <= i_cfg_data[cpm_pkg::PERIOD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    cpm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_full        (q_full),
        .i_action      (i_action),
        .i_coarse_time (i_coarse_time),
        .i_fine_phase  (i_fine_phase),
        .i_fine_valid  (i_fine_valid),
        .i_position    (i_position),
        .i_event_tag   (i_event_tag),
        .i_window      (r_window),
        .i_delay       (r_delay),
        .o_accept      (front_accept),
        .o_rec         (front_rec)
    );

    cpm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_accept),
        .i_rec   (front_rec),
        .i_take  (q_take),
        .o_valid (q_valid),
        .o_rec   (q_rec),
        .o_full  (q_full)
    );

    cpm_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_rec          (q_rec),
        .i_period         (r_period),
        .i_pop            (pop),
        .o_q_take         (q_take),
        .o_empty          (empty),
        .o_kind           (o_kind),
        .o_need_side      (o_need_side),
        .o_event_time     (o_event_time),
        .o_coarse_diff    (o_coarse_diff),
        .o_fine_diff_ps   (o_fine_diff_ps),
        .o_left_tag       (o_left_tag),
        .o_right_tag      (o_right_tag),
        .o_accepted_count (o_accepted_count),
        .o_dropped_count  (o_dropped_count)
    );

endmodule

/* tb/sv/cpm_pair_checker.sv */
// pair checker: predicts each result of the coincidence pair merger and compares it
module cpm_pair_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [cpm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cpm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             push,
    input  logic                             full,
    input  logic                             i_action,
    input  logic [cpm_pkg::TIME_BITS-1:0]    i_coarse_time,
    input  logic [cpm_pkg::PHASE_BITS-1:0]   i_fine_phase,
    input  logic                             i_fine_valid,
    input  logic [cpm_pkg::POS_BITS-1:0]     i_position,
    input  logic [cpm_pkg::TAG_BITS-1:0]     i_event_tag,
    input  logic                             empty,
    input  logic                             pop,
    input  logic [cpm_pkg::KIND_W-1:0]       i_kind,
    input  logic [cpm_pkg::NEED_W-1:0]       i_need_side,
    input  logic [cpm_pkg::TIME_BITS-1:0]    i_event_time,
    input  logic [cpm_pkg::CDIFF_W-1:0]      i_coarse_diff,
    input  logic [cpm_pkg::FDIFF_W-1:0]      i_fine_diff_ps,
    input  logic [cpm_pkg::TAG_BITS-1:0]     i_left_tag,
    input  logic [cpm_pkg::TAG_BITS-1:0]     i_right_tag,
    input  logic [cpm_pkg::CNT_W-1:0]        i_accepted_count,
    input  logic [cpm_pkg::CNT_W-1:0]        i_dropped_count,
    output int                               o_mismatches,
    output int                               o_pending
);
    import cpm_pkg::*;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [NEED_W-1:0]    need_side;
        logic [TIME_BITS-1:0] event_time;
        logic [CDIFF_W-1:0]   coarse_diff;
        logic [FDIFF_W-1:0]   fine_diff_ps;
        logic [TAG_BITS-1:0]  left_tag;
        logic [TAG_BITS-1:0]  right_tag;
        logic [CNT_W-1:0]     accepted_count;
        logic [CNT_W-1:0]     dropped_count;
    } pair_result_t;

    logic                       left_held;
    logic                       right_held;
    t_event                     left_ev;
    t_event                     right_ev;
    logic [CNT_W-1:0]           accepted_total;
    logic [CNT_W-1:0]           dropped_total;
    logic [WIN_W-1:0]           window;
    logic signed [DELAY_W-1:0]  delay;
    logic [PERIOD_W-1:0]        period_ps;
    pair_result_t               pair_results_q[$];
    int                         mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    function automatic bit coinc_window_hit(input logic [TIME_BITS-1:0] lt,
                                            input logic [TIME_BITS-1:0] rt,
                                            output longint diff);
        longint span_lim;
        longint v;
        span_lim = longint'(1) << CDIFF_W;
        diff = (lt >= rt) ? longint'(lt - rt) : -longint'(rt - lt);
        if (diff >= span_lim || diff <= -span_lim) return 1'b0;
        v = diff + longint'(delay);
        if (v < 0) v = -v;
        return v < longint'(window);
    endfunction

    function automatic logic [FDIFF_W-1:0] scaled_phase_diff(input logic [PHASE_BITS-1:0] pl,
                                                             input logic [PHASE_BITS-1:0] pr);
        longint span;
        longint half_span;
        longint d;
        longint mag;
        span = longint'(1) << PHASE_BITS;
        half_span = span / 2;
        d = longint'(pl) - longint'(pr);
        if (d < -half_span) d += span;
        if (d > half_span) d -= span;
        mag = ((d < 0 ? -d : d) * longint'(period_ps) + half_span) >>> PHASE_BITS;
        if (d < 0) mag = -mag;
        if (mag > (longint'(1) << (FDIFF_W - 1)) - 1) mag = (longint'(1) << (FDIFF_W - 1)) - 1;
        if (mag < -(longint'(1) << (FDIFF_W - 1))) mag = -(longint'(1) << (FDIFF_W - 1));
        return mag[FDIFF_W-1:0];
    endfunction

    function automatic pair_result_t merge_single(input logic action, input t_event ev);
        pair_result_t res;
        longint cd;
        res = '0;
        if (action == ACTION_LEFT ? left_held : right_held) begin
            res.kind = KIND_OVERRUN;
        end else begin
            if (action == ACTION_LEFT) begin
                left_ev = ev;
                left_held = 1'b1;
            end else begin
                right_ev = ev;
                right_held = 1'b1;
            end
            if (left_held && right_held) begin
                if (coinc_window_hit(left_ev.coarse_time, right_ev.coarse_time, cd)) begin
                    res.event_time = left_ev.coarse_time;
                    res.coarse_diff = cd[CDIFF_W-1:0];
                    res.fine_diff_ps = scaled_phase_diff(left_ev.fine_phase, right_ev.fine_phase);
                    res.left_tag = left_ev.event_tag;
                    res.right_tag = right_ev.event_tag;
                    if (left_ev.fine_valid && right_ev.fine_valid &&
                        left_ev.position == right_ev.position) begin
                        res.kind = KIND_ACCEPT;
                        accepted_total++;
                    end else begin
                        res.kind = KIND_REJECT;
                    end
                    left_held = 1'b0;
                    right_held = 1'b0;
                end else begin
                    dropped_total++;
                    // earlier single goes, the right one on equal times
                    if (left_ev.coarse_time < right_ev.coarse_time) begin
                        res.kind = KIND_LDROP;
                        res.left_tag = left_ev.event_tag;
                        left_held = 1'b0;
                    end else begin
                        res.kind = KIND_RDROP;
                        res.right_tag = right_ev.event_tag;
                        right_held = 1'b0;
                    end
                end
            end
        end
        if (left_held && !right_held) res.need_side = NEED_RIGHT;
        else if (right_held && !left_held) res.need_side = NEED_LEFT;
        else res.need_side = NEED_EITHER;
        res.accepted_count = accepted_total;
        res.dropped_count = dropped_total;
        return res;
    endfunction

    task automatic compare_field(input string label, input logic [63:0] want_v,
                                 input logic [63:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s expected %0h actual %0h", $time, label, want_v, got_v);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_event ev;
        pair_result_t want;
        if (!i_rst_n) begin
            left_held = 1'b0;
            right_held = 1'b0;
            left_ev = '0;
            right_ev = '0;
            accepted_total = '0;
            dropped_total = '0;
            window = WINDOW_RST;
            delay = DELAY_RST;
            period_ps = PERIOD_RST;
            pair_results_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WINDOW: window = i_cfg_data[WIN_W-1:0];
                    CFG_DELAY:  delay = i_cfg_data[DELAY_W-1:0];
                    CFG_PERIOD: period_ps = i_cfg_data[PERIOD_W-1:0];
                    default: ;
                endcase
            end
            if (push && !full) begin
                ev.coarse_time = i_coarse_time;
                ev.fine_phase = i_fine_phase;
                ev.fine_valid = i_fine_valid;
                ev.position = i_position;
                ev.event_tag = i_event_tag;
                pair_results_q.push_back(merge_single(i_action, ev));
            end
            if (pop && !empty) begin
                if (pair_results_q.size() == 0) begin
                    $display("%0t: result with no item waiting, expected none actual kind %0d",
                             $time, i_kind);
                    mismatch_count++;
                end else begin
                    want = pair_results_q.pop_front();
                    compare_field("kind", want.kind, i_kind);
                    compare_field("need_side", want.need_side, i_need_side);
                    compare_field("event_time", want.event_time, i_event_time);
                    compare_field("coarse_diff", want.coarse_diff, i_coarse_diff);
                    compare_field("fine_diff_ps", want.fine_diff_ps, i_fine_diff_ps);
                    compare_field("left_tag", want.left_tag, i_left_tag);
                    compare_field("right_tag", want.right_tag, i_right_tag);
                    compare_field("accepted_count", want.accepted_count, i_accepted_count);
                    compare_field("dropped_count", want.dropped_count, i_dropped_count);
                end
            end
        end
        o_pending <= pair_results_q.size();
    end

endmodule

/* tb/sv/testbench.sv */
// testbench top: drives singles and configuration into the merger and gives the verdict
module testbench;
    import cpm_pkg::*;

    localparam logic ACTION_RIGHT = ~ACTION_LEFT;
    localparam int   CYCLE_LIMIT  = 200000;
    localparam int   HOLD_CYCLES  = 150;
    localparam int   TAIL_CYCLES  = 10;
    localparam int   BATCHES      = 5;
    localparam int   BATCH_ITEMS  = 50;
    localparam int   MAX_SPREAD   = 100000;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [CFG_IDX_W-1:0]        i_cfg_idx;
    logic [CFG_DATA_W-1:0]       i_cfg_data;
    logic                        push;
    logic                        full;
    logic                        i_action;
    logic [TIME_BITS-1:0]        i_coarse_time;
    logic [PHASE_BITS-1:0]       i_fine_phase;
    logic                        i_fine_valid;
    logic [POS_BITS-1:0]         i_position;
    logic [TAG_BITS-1:0]         i_event_tag;
    logic                        empty;
    logic                        pop;
    logic [KIND_W-1:0]           o_kind;
    logic [NEED_W-1:0]           o_need_side;
    logic [TIME_BITS-1:0]        o_event_time;
    logic signed [CDIFF_W-1:0]   o_coarse_diff;
    logic signed [FDIFF_W-1:0]   o_fine_diff_ps;
    logic [TAG_BITS-1:0]         o_left_tag;
    logic [TAG_BITS-1:0]         o_right_tag;
    logic [CNT_W-1:0]            o_accepted_count;
    logic [CNT_W-1:0]            o_dropped_count;

    int                          mismatches;
    int                          pending_results;
    int                          tx_idle_pct;
    int                          rx_idle_pct;
    bit                          hold_request;
    int                          items_sent;
    int                          cycle_count;
    logic [WIN_W-1:0]            cur_window;
    logic signed [DELAY_W-1:0]   cur_delay;

    coincidence_pair_merger_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .push             (push),
        .full             (full),
        .i_action         (i_action),
        .i_coarse_time    (i_coarse_time),
        .i_fine_phase     (i_fine_phase),
        .i_fine_valid     (i_fine_valid),
        .i_position       (i_position),
        .i_event_tag      (i_event_tag),
        .empty            (empty),
        .pop              (pop),
        .o_kind           (o_kind),
        .o_need_side      (o_need_side),
        .o_event_time     (o_event_time),
        .o_coarse_diff    (o_coarse_diff),
        .o_fine_diff_ps   (o_fine_diff_ps),
        .o_left_tag       (o_left_tag),
        .o_right_tag      (o_right_tag),
        .o_accepted_count (o_accepted_count),
        .o_dropped_count  (o_dropped_count)
    );

    cpm_pair_checker pair_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .push             (push),
        .full             (full),
        .i_action         (i_action),
        .i_coarse_time    (i_coarse_time),
        .i_fine_phase     (i_fine_phase),
        .i_fine_valid     (i_fine_valid),
        .i_position       (i_position),
        .i_event_tag      (i_event_tag),
        .empty            (empty),
        .pop              (pop),
        .i_kind           (o_kind),
        .i_need_side      (o_need_side),
        .i_event_time     (o_event_time),
        .i_coarse_diff    (o_coarse_diff),
        .i_fine_diff_ps   (o_fine_diff_ps),
        .i_left_tag       (o_left_tag),
        .i_right_tag      (o_right_tag),
        .i_accepted_count (o_accepted_count),
        .i_dropped_count  (o_dropped_count),
        .o_mismatches     (mismatches),
        .o_pending        (pending_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic offer_single(input logic action, input logic [TIME_BITS-1:0] stamp,
                                input logic [PHASE_BITS-1:0] phase, input logic vld,
                                input logic [POS_BITS-1:0] pos);
        while ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push          <= 1'b1;
        i_action      <= action;
        i_coarse_time <= stamp;
        i_fine_phase  <= phase;
        i_fine_valid  <= vld;
        i_position    <= pos;
        i_event_tag   <= 16'($urandom);
        do @(posedge i_clk); while (full);
        items_sent++;
    endtask

    task automatic settle_idle();
        push <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
    endtask

    task automatic write_config(input logic [WIN_W-1:0] win, input logic [DELAY_W-1:0] dly,
                                input logic [PERIOD_W-1:0] per);
        settle_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_WINDOW;
        i_cfg_data <= CFG_DATA_W'(win);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_DELAY;
        i_cfg_data <= CFG_DATA_W'(dly);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_PERIOD;
        i_cfg_data <= CFG_DATA_W'(per);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_window = win;
        cur_delay  = dly;
    endtask

    // receiver, with one long hold-off per request
    initial begin
        int held;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++) begin
                    pop <= 1'b0;
                    @(posedge i_clk);
                end
            end else begin
                pop <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge i_clk);
        $display("[coincidence_pair_merger_unit] ERROR");
        $finish;
    end

    initial begin
        int                    phase_no;
        int                    batch;
        int                    batch_end;
        int                    sel;
        int                    w;
        longint                off;
        logic [TIME_BITS-1:0]  t_now;
        logic [TIME_BITS-1:0]  lt;
        logic [TIME_BITS-1:0]  rt;
        logic [PHASE_BITS-1:0] ph_l;
        logic [PHASE_BITS-1:0] ph_r;
        logic [POS_BITS-1:0]   pos_l;
        logic [POS_BITS-1:0]   pos_r;
        logic [WIN_W-1:0]      win;
        logic [DELAY_W-1:0]    dly;
        logic [PERIOD_W-1:0]   per;
        logic                  side;

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_WINDOW;
        i_cfg_data    <= '0;
        push          <= 1'b0;
        i_action      <= ACTION_LEFT;
        i_coarse_time <= '0;
        i_fine_phase  <= '0;
        i_fine_valid  <= 1'b0;
        i_position    <= '0;
        i_event_tag   <= '0;
        hold_request  = 1'b0;
        items_sent    = 0;
        cur_window    = WINDOW_RST;
        cur_delay     = DELAY_RST;
        tx_idle_pct   = 24;
        rx_idle_pct   = 79;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset configuration: wait, overrun, accept, reject, drops, wrapped phase
        offer_single(ACTION_LEFT,  48'd100, 16'h0000, 1'b1, 8'd5);
        offer_single(ACTION_LEFT,  48'd101, 16'h0000, 1'b1, 8'd5);
        offer_single(ACTION_RIGHT, 48'd105, 16'h8000, 1'b1, 8'd5);
        offer_single(ACTION_RIGHT, 48'd200, 16'h0000, 1'b1, 8'd3);
        offer_single(ACTION_LEFT,  48'd195, 16'h8001, 1'b1, 8'd3);
        offer_single(ACTION_LEFT,  48'd300, 16'h1234, 1'b0, 8'd7);
        offer_single(ACTION_RIGHT, 48'd300, 16'hFFFF, 1'b1, 8'd7);
        offer_single(ACTION_LEFT,  48'd400, 16'h0000, 1'b1, 8'd0);
        offer_single(ACTION_RIGHT, 48'd405, 16'h0000, 1'b1, 8'hFF);
        offer_single(ACTION_RIGHT, 48'd500, 16'h0100, 1'b1, 8'd1);
        offer_single(ACTION_LEFT,  48'd490, 16'h0200, 1'b1, 8'd1);
        offer_single(ACTION_RIGHT, 48'd520, 16'h0300, 1'b1, 8'd1);
        offer_single(ACTION_LEFT,  48'd495, 16'h0400, 1'b1, 8'd1);
        offer_single(ACTION_LEFT,  48'h0, 16'hFFFF, 1'b1, 8'hFF);
        offer_single(ACTION_RIGHT, 48'hFFFF_FFFF_FFFF, 16'h0000, 1'b1, 8'hFF);
        offer_single(ACTION_LEFT,  48'hFFFF_FFFF_FFF8, 16'hAAAA, 1'b1, 8'hFF);

        // equal times outside the window, zero period, difference past the coarse range
        write_config(20'd5, 21'h0FFFFF, 20'd0);
        offer_single(ACTION_LEFT,  48'd1000, 16'h0000, 1'b1, 8'd2);
        offer_single(ACTION_RIGHT, 48'd1000, 16'h4000, 1'b1, 8'd2);
        offer_single(ACTION_RIGHT, 48'd1049575, 16'h4000, 1'b1, 8'd2);
        offer_single(ACTION_LEFT,  48'd0, 16'h0000, 1'b1, 8'd2);
        offer_single(ACTION_RIGHT, 48'd8388608, 16'h0000, 1'b1, 8'd2);
        offer_single(ACTION_LEFT,  48'd7340033, 16'h5555, 1'b1, 8'd2);

        // widest window, most negative delay, longest period: saturated fine difference
        write_config(20'hFFFFF, 21'h100000, 20'hFFFFF);
        offer_single(ACTION_LEFT,  48'd2000000, 16'h8000, 1'b1, 8'd9);
        offer_single(ACTION_RIGHT, 48'd951424, 16'h0000, 1'b1, 8'd9);
        offer_single(ACTION_RIGHT, 48'd10000000, 16'h8000, 1'b1, 8'd9);
        offer_single(ACTION_LEFT,  48'd11048576, 16'h0000, 1'b1, 8'd9);

        t_now = 48'd1000;
        for (phase_no = 0; phase_no < 3; phase_no++) begin
            case (phase_no)
                0: begin tx_idle_pct = 24; rx_idle_pct = 79; end
                1: begin tx_idle_pct = 79; rx_idle_pct = 24; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            for (batch = 0; batch < BATCHES; batch++) begin
                case ($urandom_range(9))
                    0: win = '0;
                    1: win = '1;
                    2: win = 20'd1;
                    default: win = WIN_W'($urandom_range(2, 4096));
                endcase
                case ($urandom_range(7))
                    0: dly = '0;
                    1: dly = 21'h100000;
                    2: dly = 21'h0FFFFF;
                    3: dly = DELAY_W'($urandom);
                    default: dly = DELAY_W'(int'($urandom_range(400)) - 200);
                endcase
                case ($urandom_range(7))
                    0: per = '0;
                    1: per = 20'd1;
                    2: per = '1;
                    3: per = 20'd1000;
                    default: per = PERIOD_W'($urandom_range(1, 1048575));
                endcase
                write_config(win, dly, per);
                if (batch == 1) hold_request = 1'b1;
                batch_end = items_sent + BATCH_ITEMS;
                while (items_sent < batch_end) begin
                    sel = $urandom_range(99);
                    w = (cur_window > MAX_SPREAD) ? MAX_SPREAD : int'(cur_window);
                    t_now += TIME_BITS'($urandom_range(1, 2 * w + 50));
                    if ($urandom_range(63) == 0) t_now = {16'($urandom), 32'($urandom)};
                    lt = t_now;
                    ph_l = ($urandom_range(9) == 0) ? 16'h8000 : 16'($urandom);
                    ph_r = ($urandom_range(9) == 0) ? 16'h0000 : 16'($urandom);
                    pos_l = 8'($urandom);
                    pos_r = ($urandom_range(99) < 85) ? pos_l : 8'($urandom);
                    side = $urandom_range(1) ? ACTION_RIGHT : ACTION_LEFT;
                    if (sel < 75) begin
                        // well-formed pair around the delayed window
                        off = longint'($urandom_range(2 * w + 4)) - longint'(w + 2);
                        rt = lt + TIME_BITS'(longint'(cur_delay) + off);
                        if (side == ACTION_LEFT) begin
                            offer_single(ACTION_LEFT, lt, ph_l, $urandom_range(99) < 93, pos_l);
                            offer_single(ACTION_RIGHT, rt, ph_r, $urandom_range(99) < 93, pos_r);
                        end else begin
                            offer_single(ACTION_RIGHT, rt, ph_r, $urandom_range(99) < 93, pos_r);
                            offer_single(ACTION_LEFT, lt, ph_l, $urandom_range(99) < 93, pos_l);
                        end
                    end else if (sel < 87) begin
                        offer_single(side, lt, ph_l, 1'($urandom_range(1)), pos_l);
                    end else if (sel < 94) begin
                        offer_single(side, lt, ph_l, 1'($urandom_range(1)), pos_l);
                        offer_single(side, lt + TIME_BITS'($urandom_range(20)), ph_r,
                                     1'($urandom_range(1)), pos_r);
                    end else begin
                        offer_single(side, {16'($urandom), 32'($urandom)}, ph_l,
                                     1'($urandom_range(1)), pos_l);
                    end
                end
            end
        end

        settle_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_results == 0) begin
            $display("[coincidence_pair_merger_unit] OK");
        end else begin
            $display("[coincidence_pair_merger_unit] ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/cpm_pkg.sv
sv/cpm_front.sv
sv/cpm_queue.sv
sv/cpm_back.sv
sv/coincidence_pair_merger_unit.sv
tb/sv/cpm_pair_checker.sv
tb/sv/testbench.sv
